[hw/rtl/kts_pkg.sv]
// Shared constants, types and helpers for the Kalman trajectory smoother.
// No dependencies; every other file of the block imports this package.
package kts_pkg;

   localparam int REG_BITS          = 24;
   localparam int VALUE_BITS_DEF    = 32;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int CSR_INDEX_BITS    = 2;

   localparam logic [REG_BITS-1:0] PROCESS_NOISE_RST = 24'd655;
   localparam logic [REG_BITS-1:0] MEASURE_NOISE_RST = 24'd6554;
   localparam logic [REG_BITS-1:0] INITIAL_COV_RST   = 24'd6554;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PROCESS_NOISE = 2'd0,
      CSR_MEASURE_NOISE = 2'd1,
      CSR_INITIAL_COV   = 2'd2
   } csr_index_type;

   // Status of a serial arithmetic unit, seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

[hw/rtl/kts_req_if.sv]
// Request channel of the trajectory smoother: one motion word per frame.
// Depends on kts_pkg for the default value width.
interface kts_req_if
   import kts_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] step_x;
   logic signed [VALUE_BITS-1:0] step_y;
   logic signed [VALUE_BITS-1:0] step_angle;
   logic                         motion_found;

   modport source (output valid, step_x, step_y, step_angle, motion_found, input ready);
   modport sink   (input valid, step_x, step_y, step_angle, motion_found, output ready);
endinterface

[hw/rtl/kts_rsp_if.sv]
// Response channel of the trajectory smoother: corrected motion and smoothed totals.
// Depends on kts_pkg for the default value width.
interface kts_rsp_if
   import kts_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] fixed_x;
   logic signed [VALUE_BITS-1:0] fixed_y;
   logic signed [VALUE_BITS-1:0] fixed_angle;
   logic signed [VALUE_BITS-1:0] smooth_x;
   logic signed [VALUE_BITS-1:0] smooth_y;
   logic signed [VALUE_BITS-1:0] smooth_angle;

   modport source (output valid, fixed_x, fixed_y, fixed_angle,
                   smooth_x, smooth_y, smooth_angle, input ready);
   modport sink   (input valid, fixed_x, fixed_y, fixed_angle,
                   smooth_x, smooth_y, smooth_angle, output ready);
endinterface

[hw/rtl/kalman_trajectory_smoother_core.sv]
// Top level of the Kalman trajectory smoother: sequencer, state and output register.
// Depends on kts_pkg, kts_req_if, kts_rsp_if, kts_serial_div and kts_serial_mul.
//
//   channel   direction  handshake            word
//   req_port  in         valid/ready          step_x, step_y, step_angle, motion_found
//   rsp_port  out        valid/ready          fixed_x/y/angle, smooth_x/y/angle
//   csr_*     in         csr_we, no wait      csr_index selects q, r or initial P
//
// A word that yields a result passes through predict, the bit-serial gain divider and
// the four shift-add lanes that run side by side, then the output state. With zero
// measurement noise the divider answers at once. A dropped word, or the one that starts
// the filter, leaves the block in its idle state. Reset is synchronous and active high;
// it clears the filter state, not the output words, and loads register defaults.
// A finished result waits in the output register while the next word is accepted;
// only a second result stalls, in the output state, until rsp_port.ready frees it.
module kalman_trajectory_smoother_core
   import kts_pkg::*;
#(
   parameter int VALUE_BITS    = VALUE_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   kts_req_if.sink                    req_port,
   kts_rsp_if.source                  rsp_port,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [REG_BITS-1:0]        csr_data
);
   localparam int VB    = VALUE_BITS;
   localparam int FB    = FRACTION_BITS;
   localparam int MW    = max_int(VB, REG_BITS);
   localparam int DW    = MW + 1;
   localparam int AW    = VB + 1;
   localparam int KW    = FB + 1;
   localparam int AXES  = 3;
   localparam int LANES = AXES + 1;
   localparam logic [KW-1:0]        UNITY = {1'b1, {FB{1'b0}}};
   localparam logic signed [VB-1:0] VMAX  = {1'b0, {(VB-1){1'b1}}};
   localparam logic signed [VB-1:0] VMIN  = {1'b1, {(VB-1){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREDICT,
      S_GAIN_START,
      S_GAIN,
      S_UPDATE_START,
      S_UPDATE,
      S_OUTPUT
   } state_type;

   state_type               state_ff;
   logic [REG_BITS-1:0]     q_ff;
   logic [REG_BITS-1:0]     r_ff;
   logic [REG_BITS-1:0]     init_ff;
   logic signed [VB-1:0]    tot_ff    [AXES];
   logic signed [VB-1:0]    est_ff    [AXES];
   logic signed [VB-1:0]    motion_ff [AXES];
   logic signed [VB-1:0]    fixed_ff  [AXES];
   logic signed [VB-1:0]    smooth_ff [AXES];
   logic                    neg_ff    [AXES];
   logic [MW-1:0]           cov_ff;
   logic [VB-1:0]           p_ff;
   logic [KW-1:0]           k_ff;
   logic                    started_ff;
   logic                    have_last_ff;
   logic                    rsp_valid_ff;

   logic                    accept;
   logic                    take;
   logic signed [VB-1:0]    step_in   [AXES];
   logic signed [VB-1:0]    motion_in [AXES];
   logic signed [VB:0]      tot_sum   [AXES];
   logic signed [VB-1:0]    tot_in    [AXES];
   logic [DW-1:0]           p_sum;
   logic [VB-1:0]           p_in;
   logic signed [VB:0]      diff      [AXES];
   logic [VB:0]             est_sum   [AXES];
   logic signed [VB-1:0]    est_in    [AXES];
   logic signed [VB+1:0]    fix_sum   [AXES];
   logic signed [VB-1:0]    fix_in    [AXES];
   logic [AW-1:0]           lane_a    [LANES];
   logic [KW-1:0]           lane_b    [LANES];
   logic [AW-1:0]           lane_prod [LANES];
   unit_status_type         lane_sts  [LANES];
   logic [KW-1:0]           div_quot;
   unit_status_type         div_sts;

   // --- word intake and datapath around the serial units ---
   always_comb begin
      accept     = req_port.valid && req_port.ready;
      take       = req_port.motion_found || have_last_ff;
      step_in[0] = req_port.step_x;
      step_in[1] = req_port.step_y;
      step_in[2] = req_port.step_angle;

      for (int i = 0; i < AXES; i++) begin
         // reuse the last found motion when this frame has none
         motion_in[i] = req_port.motion_found ? step_in[i] : motion_ff[i];
         tot_sum[i]   = (VB+1)'(tot_ff[i]) + (VB+1)'(motion_in[i]);
         if (tot_sum[i][VB] != tot_sum[i][VB-1]) begin
            tot_in[i] = tot_sum[i][VB] ? VMIN : VMAX;
         end else begin
            tot_in[i] = tot_sum[i][VB-1:0];
         end

         // innovation magnitude feeds lanes 0..2; its sign is kept in neg_ff
         diff[i]   = (VB+1)'(tot_ff[i]) - (VB+1)'(est_ff[i]);
         lane_a[i] = diff[i][VB] ? AW'(-diff[i]) : AW'(diff[i]);
         lane_b[i] = k_ff;

         est_sum[i] = neg_ff[i] ? ({est_ff[i][VB-1], est_ff[i]} - lane_prod[i])
                                : ({est_ff[i][VB-1], est_ff[i]} + lane_prod[i]);
         est_in[i]  = est_sum[i][VB-1:0];

         // corrected motion from the already updated estimate
         fix_sum[i] = (VB+2)'(motion_ff[i]) + (VB+2)'(est_ff[i]) - (VB+2)'(tot_ff[i]);
         if ((fix_sum[i][VB+1:VB-1] == 3'b000) || (fix_sum[i][VB+1:VB-1] == 3'b111)) begin
            fix_in[i] = fix_sum[i][VB-1:0];
         end else begin
            fix_in[i] = fix_sum[i][VB+1] ? VMIN : VMAX;
         end
      end

      // lane 3 shrinks the covariance: P = (1 - K) * P
      lane_a[AXES] = AW'(p_ff);
      lane_b[AXES] = UNITY - k_ff;

      // predict with saturation to the value range
      p_sum = DW'(cov_ff) + DW'(q_ff);
      p_in  = (p_sum[DW-1:VB] != '0) ? '1 : p_sum[VB-1:0];
   end

   kts_serial_div #(
      .VALUE_BITS    (VALUE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_GAIN_START),
      .numer    (p_ff),
      .noise    (r_ff),
      .quotient (div_quot),
      .status   (div_sts)
   );

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      kts_serial_mul #(
         .VALUE_BITS    (VALUE_BITS),
         .FRACTION_BITS (FRACTION_BITS)
      ) u_mul (
         .clock        (clock),
         .reset        (reset),
         .start        (state_ff == S_UPDATE_START),
         .multiplicand (lane_a[g]),
         .multiplier   (lane_b[g]),
         .product      (lane_prod[g]),
         .status       (lane_sts[g])
      );
   end

   // --- sequencer, filter state and output register ---
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         q_ff         <= PROCESS_NOISE_RST;
         r_ff         <= MEASURE_NOISE_RST;
         init_ff      <= INITIAL_COV_RST;
         cov_ff       <= '0;
         started_ff   <= 1'b0;
         have_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            tot_ff[i]    <= '0;
            est_ff[i]    <= '0;
            motion_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_PROCESS_NOISE: q_ff    <= csr_data;
               CSR_MEASURE_NOISE: r_ff    <= csr_data;
               CSR_INITIAL_COV:   init_ff <= csr_data;
               default: ;
            endcase
         end

         // drop the valid flag once the result word is taken; the output state
         // reloads it itself when a new result replaces the taken one
         if (rsp_valid_ff && rsp_port.ready && (state_ff != S_OUTPUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               // a word with no motion ever seen is dropped without a trace
               if (accept && take) begin
                  for (int i = 0; i < AXES; i++) begin
                     motion_ff[i] <= motion_in[i];
                     tot_ff[i]    <= tot_in[i];
                  end
                  if (req_port.motion_found) begin
                     have_last_ff <= 1'b1;
                  end
                  if (!started_ff) begin
                     // first usable word only updates the totals and motion and loads the covariance
                     started_ff <= 1'b1;
                     cov_ff     <= MW'(init_ff);
                  end else begin
                     state_ff <= S_PREDICT;
                  end
               end
            end
            S_PREDICT: begin
               p_ff     <= p_in;
               state_ff <= S_GAIN_START;
            end
            S_GAIN_START: begin
               state_ff <= S_GAIN;
            end
            S_GAIN: begin
               if (div_sts.done) begin
                  k_ff     <= div_quot;
                  state_ff <= S_UPDATE_START;
               end
            end
            S_UPDATE_START: begin
               for (int i = 0; i < AXES; i++) begin
                  neg_ff[i] <= diff[i][VB];
               end
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               // all lanes start together and finish together
               if (lane_sts[0].done) begin
                  for (int i = 0; i < AXES; i++) begin
                     est_ff[i] <= est_in[i];
                  end
                  cov_ff   <= MW'(lane_prod[AXES][VB-1:0]);
                  state_ff <= S_OUTPUT;
               end
            end
            S_OUTPUT: begin
               // hold here while an earlier result still waits
               if (!rsp_valid_ff || rsp_port.ready) begin
                  for (int i = 0; i < AXES; i++) begin
                     fixed_ff[i]  <= fix_in[i];
                     smooth_ff[i] <= est_ff[i];
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_port.ready        = (state_ff == S_IDLE);
   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.fixed_x      = fixed_ff[0];
   assign rsp_port.fixed_y      = fixed_ff[1];
   assign rsp_port.fixed_angle  = fixed_ff[2];
   assign rsp_port.smooth_x     = smooth_ff[0];
   assign rsp_port.smooth_y     = smooth_ff[1];
   assign rsp_port.smooth_angle = smooth_ff[2];

   // --- checks on the sequencer ---
   a_div_done_in_gain: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == S_GAIN))
      else $error("gain divider finished outside the gain state");

   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      lane_sts[0].done |-> (lane_sts[1].done && lane_sts[2].done && lane_sts[3].done))
      else $error("multiplier lanes out of step");

   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!div_sts.busy && !lane_sts[0].busy))
      else $error("serial unit busy while the block accepts words");

   a_gain_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE_START) |-> (k_ff <= UNITY))
      else $error("Kalman gain above one");
endmodule

[hw/rtl/kts_serial_div.sv]
// Restoring divider for the Kalman gain K = P / (P + r), one quotient bit per cycle.
// Depends on kts_pkg (register width, status type).
module kts_serial_div
   import kts_pkg::*;
#(
   parameter int VALUE_BITS    = VALUE_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [VALUE_BITS-1:0]   numer,
   input  logic [REG_BITS-1:0]     noise,
   output logic [FRACTION_BITS:0]  quotient,
   output unit_status_type         status
);
   localparam int DW = max_int(VALUE_BITS, REG_BITS) + 1;
   localparam int CW = $clog2(FRACTION_BITS + 1);
   localparam logic [FRACTION_BITS:0] UNITY = {1'b1, {FRACTION_BITS{1'b0}}};

   logic [DW-1:0]          rem_ff;
   logic [DW-1:0]          denom_ff;
   logic [FRACTION_BITS:0] quot_ff;
   logic [CW-1:0]          cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;
   logic [DW:0]            shifted_in;
   logic                   fits_in;

   always_comb begin
      shifted_in = {rem_ff, 1'b0};
      fits_in    = (shifted_in >= {1'b0, denom_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (noise == '0) begin
               // zero measurement noise: gain is one, or zero when P is zero too
               quot_ff <= (numer == '0) ? '0 : UNITY;
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               quot_ff  <= '0;
               rem_ff   <= DW'(numer);
               denom_ff <= DW'(numer) + DW'(noise);
               cnt_ff   <= CW'(FRACTION_BITS);
               busy_ff  <= 1'b1;
            end
         end else if (busy_ff) begin
            rem_ff  <= fits_in ? DW'(shifted_in - {1'b0, denom_ff}) : DW'(shifted_in);
            quot_ff <= {quot_ff[FRACTION_BITS-1:0], fits_in};
            cnt_ff  <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = quot_ff;
   assign status   = '{busy: busy_ff, done: done_ff};
endmodule

[hw/rtl/kts_serial_mul.sv]
// Shift-add multiplier lane: round(a * k / 2^FRACTION_BITS), one multiplier bit per cycle.
// Depends on kts_pkg (status type, default widths).
module kts_serial_mul
   import kts_pkg::*;
#(
   parameter int VALUE_BITS    = VALUE_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [VALUE_BITS:0]     multiplicand,
   input  logic [FRACTION_BITS:0]  multiplier,
   output logic [VALUE_BITS:0]     product,
   output unit_status_type         status
);
   localparam int AW = VALUE_BITS + 1;
   localparam int BW = FRACTION_BITS + 1;
   localparam int PW = AW + BW;
   localparam int CW = $clog2(BW + 1);
   localparam logic [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);

   logic [PW-1:0] acc_ff;
   logic [PW-1:0] a_ff;
   logic [BW-1:0] b_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            // preload the rounding half so the final shift rounds on the magnitude
            acc_ff  <= HALF;
            a_ff    <= PW'(multiplicand);
            b_ff    <= multiplier;
            cnt_ff  <= CW'(BW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (b_ff[0]) begin
               acc_ff <= acc_ff + a_ff;
            end
            a_ff   <= {a_ff[PW-2:0], 1'b0};
            b_ff   <= {1'b0, b_ff[BW-1:1]};
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign product = acc_ff[FRACTION_BITS +: AW];
   assign status  = '{busy: busy_ff, done: done_ff};
endmodule

[tb/tb_kalman_trajectory_smoother_core.sv]
`timescale 1ns / 100ps
// Self-checking bench for kalman_trajectory_smoother_core: motion words in, smoothed words out.
// Depends on kts_pkg, kts_req_if, kts_rsp_if and the core; predicts every result internally.
module tb_kalman_trajectory_smoother_core
   import kts_pkg::*;
();

   localparam int VB = VALUE_BITS_DEF;
   localparam int FB = FRACTION_BITS_DEF;

   localparam int CLOCK_HALF       = 10;
   localparam int SETTLE_CYCLES    = 100;
   localparam int LONG_HOLD_CYCLES = 1500;
   localparam int CYCLE_LIMIT      = 3_000_000;
   localparam int STEP_SPAN        = 4 << FB;  // up to four pixels either way
   localparam int PHASE_WORDS      = 200;

   typedef longint unsigned u64_t;

   localparam longint VMAX_L = (64'sd1 <<< (VB - 1)) - 1;
   localparam longint VMIN_L = -(64'sd1 <<< (VB - 1));
   localparam u64_t   VMASK_L = (64'd1 << VB) - 1;
   localparam u64_t   UNITY   = 64'd1 << FB;

   localparam logic signed [VB-1:0] STEP_MAX = {1'b0, {(VB-1){1'b1}}};
   localparam logic signed [VB-1:0] STEP_MIN = {1'b1, {(VB-1){1'b0}}};
   localparam logic [REG_BITS-1:0]  REG_FULL = '1;

   typedef struct {
      logic signed [VB-1:0] step_x;
      logic signed [VB-1:0] step_y;
      logic signed [VB-1:0] step_angle;
      logic                 motion_found;
   } motion_word_t;

   typedef struct {
      logic signed [VB-1:0] fixed_x;
      logic signed [VB-1:0] fixed_y;
      logic signed [VB-1:0] fixed_angle;
      logic signed [VB-1:0] smooth_x;
      logic signed [VB-1:0] smooth_y;
      logic signed [VB-1:0] smooth_angle;
   } smoothed_word_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [REG_BITS-1:0] csr_data;

   kts_req_if req_if ();
   kts_rsp_if rsp_if ();

   kalman_trajectory_smoother_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_if),
      .rsp_port  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Words waiting to be offered, and smoothed words the tracker says are due.
   motion_word_t   pending_words[$];
   smoothed_word_t expected_smooth[$];

   int error_count  = 0;
   int words_sent   = 0;
   int results_seen = 0;
   int settings_run = 0;

   // ---------------------------------------------------------------------------------
   // Trajectory tracker: the bench's own copy of registers and filter state.
   // ---------------------------------------------------------------------------------
   u64_t   q_reg  = u64_t'(PROCESS_NOISE_RST);
   u64_t   r_reg  = u64_t'(MEASURE_NOISE_RST);
   u64_t   p0_reg = u64_t'(INITIAL_COV_RST);
   longint trk_total[3] = '{0, 0, 0};
   longint trk_est[3]   = '{0, 0, 0};
   longint trk_last[3]  = '{0, 0, 0};
   u64_t   trk_cov      = 0;
   bit     trk_started  = 1'b0;
   bit     trk_have_last = 1'b0;

   function automatic longint clamp_value(input longint v);
      if (v > VMAX_L) return VMAX_L;
      if (v < VMIN_L) return VMIN_L;
      return v;
   endfunction

   // Fractional product, rounded half up on a magnitude; a*k stays far below 2^64 here.
   function automatic u64_t scale_round(input u64_t a, input u64_t k);
      return (a * k + (UNITY >> 1)) >> FB;
   endfunction

   // Restoring division P / (P + r), FB fraction bits, truncated.
   function automatic u64_t kalman_gain(input u64_t p, input u64_t r);
      u64_t den;
      u64_t rem;
      u64_t k;
      int   i;
      den = p + r;
      rem = p;
      k   = 0;
      if (den == 0) return 0;       // zero noise and zero covariance
      if (p >= den) return UNITY;   // zero measurement noise
      for (i = 0; i < FB; i++) begin
         rem = rem << 1;
         k   = k << 1;
         if (rem >= den) begin
            rem = rem - den;
            k   = k | 64'd1;
         end
      end
      return k;
   endfunction

   // Advance the tracker by one accepted word; queue a smoothed word if one is due.
   function automatic void track_motion(input motion_word_t w);
      longint         m[3];
      longint         fixed_v[3];
      longint         diff;
      u64_t           p;
      u64_t           k;
      u64_t           mag;
      u64_t           delta;
      smoothed_word_t res;
      int             i;
      if (w.motion_found) begin
         m[0] = w.step_x;
         m[1] = w.step_y;
         m[2] = w.step_angle;
         trk_last = m;
         trk_have_last = 1'b1;
      end else if (trk_have_last) begin
         m = trk_last;
      end else begin
         return;   // nothing found yet: drop, no state change
      end

      for (i = 0; i < 3; i++) trk_total[i] = clamp_value(trk_total[i] + m[i]);

      if (!trk_started) begin
         trk_started = 1'b1;
         trk_cov = p0_reg;
         return;
      end

      p = trk_cov + q_reg;
      if (p > VMASK_L) p = VMASK_L;
      k = kalman_gain(p, r_reg);
      for (i = 0; i < 3; i++) begin
         diff  = trk_total[i] - trk_est[i];
         mag   = (diff < 0) ? u64_t'(-diff) : u64_t'(diff);
         delta = scale_round(mag, k);
         trk_est[i] = (diff < 0) ? trk_est[i] - longint'(delta) : trk_est[i] + longint'(delta);
         fixed_v[i] = clamp_value(m[i] + trk_est[i] - trk_total[i]);
      end
      trk_cov = scale_round(p, UNITY - k);

      res.fixed_x      = VB'(fixed_v[0]);
      res.fixed_y      = VB'(fixed_v[1]);
      res.fixed_angle  = VB'(fixed_v[2]);
      res.smooth_x     = VB'(trk_est[0]);
      res.smooth_y     = VB'(trk_est[1]);
      res.smooth_angle = VB'(trk_est[2]);
      expected_smooth.insert(expected_smooth.size(), res);
   endfunction

   // ---------------------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------------------

   // Mostly short gaps, a few long ones; now and then a calm stretch with none at all.
   function automatic int pick_gap(inout int calm_left);
      int sel;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (sel < 45) return 0;
      if (sel < 85) return $urandom_range(1, 4);
      if (sel < 97) return $urandom_range(5, 30);
      return $urandom_range(60, 200);
   endfunction

   // Camera-like small shifts most of the time, full-range noise and extremes otherwise.
   function automatic logic signed [VB-1:0] pick_step();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70) return VB'(int'($urandom_range(0, 2 * STEP_SPAN)) - STEP_SPAN);
      if (sel < 85) return $urandom;
      if (sel < 90) return STEP_MAX;
      if (sel < 95) return STEP_MIN;
      return VB'(int'($urandom_range(0, 6)) - 3);
   endfunction

   function automatic logic [REG_BITS-1:0] pick_noise();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel == 1) return REG_FULL;
      if (sel < 6)  return REG_BITS'($urandom_range(1, 2000));
      if (sel < 9)  return REG_BITS'($urandom_range(1, 1 << 17));
      return REG_BITS'($urandom);
   endfunction

   function automatic void push_word(input logic signed [VB-1:0] x, input logic signed [VB-1:0] y,
                                     input logic signed [VB-1:0] a, input logic found);
      motion_word_t w;
      w.step_x       = x;
      w.step_y       = y;
      w.step_angle   = a;
      w.motion_found = found;
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic void queue_random_words(input int count);
      int n;
      for (n = 0; n < count; n++)
         push_word(pick_step(), pick_step(), pick_step(), $urandom_range(0, 99) < 85);
   endfunction

   // ---------------------------------------------------------------------------------
   // Driver: offer queued words on req_if, holding each until the core takes it.
   // ---------------------------------------------------------------------------------
   motion_word_t offer_word = '{default: '0};
   bit           offer_live = 1'b0;
   int           send_gap   = 0;
   int           send_calm  = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         // Word taken at this edge: advance the tracker, then rest for a while.
         if (req_if.valid && req_if.ready) begin
            track_motion(offer_word);
            words_sent++;
            offer_live = 1'b0;
            send_gap   = pick_gap(send_calm);
         end
         if (!offer_live && send_gap == 0 && pending_words.size() != 0) begin
            offer_word = pending_words.pop_front();
            offer_live = 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
         end
         req_if.valid        <= offer_live;
         req_if.step_x       <= offer_word.step_x;
         req_if.step_y       <= offer_word.step_y;
         req_if.step_angle   <= offer_word.step_angle;
         req_if.motion_found <= offer_word.motion_found;
      end
   end

   // ---------------------------------------------------------------------------------
   // Monitor: take smoothed words with random back-pressure and check each field.
   // ---------------------------------------------------------------------------------
   smoothed_word_t due_word;
   int             take_gap  = 0;
   int             take_calm = 0;
   int             long_hold = 0;

   function automatic void compare_field(input string name, input logic signed [VB-1:0] want,
                                         input logic signed [VB-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d (0x%h), got %0d (0x%h)", name, want, want, got, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_smooth.size() == 0) begin
               $error("smoothed word arrived with no prediction waiting");
               error_count++;
            end else begin
               due_word = expected_smooth.pop_front();
               compare_field("fixed_x", due_word.fixed_x, rsp_if.fixed_x);
               compare_field("fixed_y", due_word.fixed_y, rsp_if.fixed_y);
               compare_field("fixed_angle", due_word.fixed_angle, rsp_if.fixed_angle);
               compare_field("smooth_x", due_word.smooth_x, rsp_if.smooth_x);
               compare_field("smooth_y", due_word.smooth_y, rsp_if.smooth_y);
               compare_field("smooth_angle", due_word.smooth_angle, rsp_if.smooth_angle);
            end
            results_seen++;
            take_gap = pick_gap(take_calm);
            // Hold off for a long stretch twice, so the core fills and stalls its input.
            if (results_seen == 300 || results_seen == 900) long_hold = LONG_HOLD_CYCLES;
         end else if (long_hold > 0) begin
            long_hold--;
         end else if (take_gap > 0) begin
            take_gap--;
         end
         rsp_if.ready <= (long_hold == 0 && take_gap == 0);
      end
   end

   // ---------------------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------------------
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due", cycle_count,
                  expected_smooth.size());
         $display("tb_kalman_trajectory_smoother_core: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Register writes and phase sequencing
   // ---------------------------------------------------------------------------------

   // Write one register and mirror it into the tracker; only called while the core is idle.
   task automatic write_register(input csr_index_type idx, input logic [REG_BITS-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         CSR_PROCESS_NOISE: q_reg  = u64_t'(value);
         CSR_MEASURE_NOISE: r_reg  = u64_t'(value);
         CSR_INITIAL_COV:   p0_reg = u64_t'(value);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until every queued word is taken and every predicted word has come back,
   // then let the core finish a word that yields no result.
   task automatic settle_block();
      @(negedge clock);
      while (pending_words.size() != 0 || offer_live || expected_smooth.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_setting(input logic [REG_BITS-1:0] q, input logic [REG_BITS-1:0] r,
                              input int count);
      write_register(CSR_PROCESS_NOISE, q);
      write_register(CSR_MEASURE_NOISE, r);
      @(negedge clock);
      queue_random_words(count);
      settings_run++;
      settle_block();
   endtask

   initial begin
      int ph;
      csr_we              = 1'b0;
      csr_index           = CSR_PROCESS_NOISE;
      csr_data            = '0;
      req_if.valid        = 1'b0;
      req_if.step_x       = '0;
      req_if.step_y       = '0;
      req_if.step_angle   = '0;
      req_if.motion_found = 1'b0;
      rsp_if.ready        = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Full-scale covariance is loaded when the first motion starts the filter.
      write_register(CSR_INITIAL_COV, REG_FULL);
      @(negedge clock);

      // No motion found yet: drop these.
      push_word($urandom, $urandom, $urandom, 1'b0);
      push_word($urandom, $urandom, $urandom, 1'b0);
      // First found motion only starts the filter.
      push_word(3 << FB, -(2 << FB), 1000, 1'b1);
      push_word('0, '0, '0, 1'b1);
      push_word(5 << FB, 7 << FB, -500, 1'b1);
      // Motion lost: reuse the last one found, whatever the fields say.
      push_word($urandom, $urandom, $urandom, 1'b0);
      push_word($urandom, $urandom, $urandom, 1'b0);
      // Drive the totals into saturation at both ends, then back.
      push_word(STEP_MAX, STEP_MIN, STEP_MAX, 1'b1);
      push_word(STEP_MAX, STEP_MIN, STEP_MIN, 1'b1);
      push_word($urandom, $urandom, $urandom, 1'b0);
      push_word(STEP_MIN, STEP_MAX, STEP_MIN, 1'b1);
      push_word(STEP_MIN, STEP_MAX, STEP_MAX, 1'b1);
      push_word(-1, 1, 32'sh5555_5555, 1'b1);
      push_word(32'shAAAA_AAAA, 32'sh5555_5555, 32'sh8000_0001, 1'b1);
      push_word(32'sh7FFF_0000, 32'sh0000_FFFF, 32'shFFFF_0000, 1'b1);
      push_word('0, '0, '0, 1'b1);
      push_word(1 << FB, -(1 << FB), 3, 1'b1);
      push_word(-1, -1, -1, 1'b1);
      settings_run++;
      settle_block();

      // Zero noise everywhere: gain is exactly one once, then the covariance is zero
      // and the gain collapses to zero.
      run_setting('0, '0, 12);
      // Both noises at full scale.
      run_setting(REG_FULL, REG_FULL, 20);
      // No process noise against heavy measurement noise: estimates barely move.
      run_setting('0, REG_FULL, 20);
      // Heavy process noise, smallest nonzero measurement noise: estimates track totals.
      run_setting(REG_FULL, 24'd1, 20);

      // Random settings; the covariance register is rewritten too, though the filter
      // only loads it once after reset.
      for (ph = 0; ph < 6; ph++) begin
         write_register(CSR_INITIAL_COV, pick_noise());
         run_setting(pick_noise(), pick_noise(), PHASE_WORDS);
      end

      // Back to the reset values for a last short run.
      write_register(CSR_INITIAL_COV, INITIAL_COV_RST);
      run_setting(PROCESS_NOISE_RST, MEASURE_NOISE_RST, 40);

      $display("covered %0d motion words, %0d smoothed words checked, %0d dropped or starting",
               words_sent, results_seen, words_sent - results_seen);
      $display("across %0d noise settings incl. zero and full scale, %0d cycles",
               settings_run, cycle_count);
      if (error_count == 0) begin
         $display("tb_kalman_trajectory_smoother_core: done, clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tb_kalman_trajectory_smoother_core: done, errors");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/kts_pkg.sv
hw/rtl/kts_req_if.sv
hw/rtl/kts_rsp_if.sv
hw/rtl/kts_serial_div.sv
hw/rtl/kts_serial_mul.sv
hw/rtl/kalman_trajectory_smoother_core.sv
tb/tb_kalman_trajectory_smoother_core.sv
